// ===== src/hbe_pkg.sv =====
package hbe_pkg;

  // Buffer geometry and pointer width
  localparam int BUF_BYTES = 256;
  localparam int BUF_AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int PTR_W     = 12;
  localparam int BIT_LIMIT = BUF_BYTES * 8;

  // Input commands
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CODE    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE         = 2'd0;
  localparam logic [1:0] CFG_PAYLOAD_BITS = 2'd1;

  // Mode value that embeds bits into text
  localparam logic MODE_EMBED = 1'b0;

  // Alphabet: Latin letters and their Cyrillic look-alikes, slot by slot
  localparam logic [7:0] LATIN_FORM [16] = '{
    8'h41, 8'h61, 8'h42, 8'h43, 8'h63, 8'h45, 8'h65, 8'h4b,
    8'h4d, 8'h4f, 8'h6f, 8'h50, 8'h70, 8'h54, 8'h58, 8'h78
  };
  localparam logic [7:0] CYRILLIC_FORM [16] = '{
    8'h80, 8'ha0, 8'h82, 8'h91, 8'he1, 8'h85, 8'ha5, 8'h8a,
    8'h8c, 8'h8e, 8'hae, 8'h90, 8'he0, 8'h92, 8'h95, 8'he5
  };

  typedef struct packed {
    logic       hit;   // byte is one of the 32 letters
    logic       kind;  // 0 Latin, 1 Cyrillic
    logic [3:0] slot;
  } glyph_t;

  // Write port of the payload buffer
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Item held while its buffer read is in flight
  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        data;
    logic              addr_ok;
    logic [BUF_AW-1:0] addr;
    logic [2:0]        shift;
    logic              kind;
    logic [3:0]        slot;
    logic              carried;
    logic [PTR_W-1:0]  bits_done;
    logic              byte_vld;
    logic              fwd_hit;
    logic [7:0]        fwd_data;
  } s1_t;

  // Result beat
  typedef struct packed {
    logic [7:0]       result_byte;
    logic             carried;
    logic [PTR_W-1:0] bits_done;
  } res_t;

  // Match a byte against the alphabet; the two sets are disjoint
  function automatic glyph_t classify(input logic [7:0] c);
    glyph_t g;
    g = '0;
    for (int i = 0; i < 16; i++) begin
      if (LATIN_FORM[i] == c) begin
        g = '{hit: 1'b1, kind: 1'b0, slot: 4'(i)};
      end
      if (CYRILLIC_FORM[i] == c) begin
        g = '{hit: 1'b1, kind: 1'b1, slot: 4'(i)};
      end
    end
    return g;
  endfunction

endpackage

// ===== src/hbe_ram.sv =====
module hbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address written in the same cycle returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/hbe_issue.sv =====
module hbe_issue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  hbe_pkg::cmd_t               in_cmd,
  input  logic [7:0]                  in_addr,
  input  logic [7:0]                  in_data,
  input  logic [hbe_pkg::PTR_W-1:0]   pbits,
  input  hbe_pkg::wr_t                wr,
  output logic                        rd_en,
  output logic [hbe_pkg::BUF_AW-1:0]  rd_addr,
  output hbe_pkg::s1_t                s1,
  output logic                        s1_vld
);
  import hbe_pkg::*;

  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [BUF_BYTES-1:0] byte_vld_r;
  s1_t                  s1_r, s1_nxt;
  logic                 s1_vld_r;
  glyph_t               g;
  logic                 limit_ok;
  logic                 carry;
  logic                 addr_ok;
  logic                 fwd_hit;

  // Classify the text byte and check the bit limits
  always_comb begin
    g        = classify(in_data);
    limit_ok = (32'(ptr_r) < 32'(pbits)) && (32'(ptr_r) < BIT_LIMIT);
    carry    = (in_cmd == CMD_CODE) && g.hit && limit_ok;
    addr_ok  = 32'(in_addr) < BUF_BYTES;
  end

  // Advance the bit pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (acc) begin
      if (in_cmd == CMD_RESTART) begin
        ptr_nxt = '0;
      end else if (carry) begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  // Issue the buffer read; forward a write to the same byte this cycle
  always_comb begin
    rd_en   = acc;
    rd_addr = (in_cmd == CMD_CODE) ? BUF_AW'(ptr_r >> 3) : BUF_AW'(in_addr);
    fwd_hit = wr.en && (wr.addr == rd_addr);

    s1_nxt.cmd       = in_cmd;
    s1_nxt.data      = in_data;
    s1_nxt.addr_ok   = addr_ok;
    s1_nxt.addr      = rd_addr;
    s1_nxt.shift     = ptr_r[2:0];
    s1_nxt.kind      = g.kind;
    s1_nxt.slot      = g.slot;
    s1_nxt.carried   = carry;
    s1_nxt.bits_done = ptr_nxt;
    s1_nxt.byte_vld  = byte_vld_r[rd_addr];
    s1_nxt.fwd_hit   = fwd_hit;
    s1_nxt.fwd_data  = wr.data;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      byte_vld_r <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      s1_vld_r <= acc;
      if (wr.en) begin
        byte_vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  // Hold the item beside its read
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1     = s1_r;
  assign s1_vld = s1_vld_r;

endmodule

// ===== src/hbe_out_queue.sv =====
module hbe_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hbe_pkg::res_t push_item,
  input  logic          out_stall,
  output logic          out_valid,
  output hbe_pkg::res_t head,
  output logic          pop,
  output logic [1:0]    cnt
);
  import hbe_pkg::*;

  res_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  // Pop when the head beat is taken
  always_comb begin
    out_valid = cnt_r != 2'd0;
    pop       = out_valid && !out_stall;
    head      = ent_r[rp_r];
    cnt_nxt   = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  assign cnt = cnt_r;

endmodule

// ===== src/homoglyph_bit_embed_codec.sv =====
// Channel  | Handshake                  | Payload
// config   | cfg_we                     | cfg_index, cfg_data
// input    | in_valid / in_stall        | in_command, in_address, in_data_byte
// result   | out_valid / out_stall      | out_result_byte, out_carried, out_bits_done
//
// One item per cycle while in_stall is low; each result is registered beside its buffer read, then in the result queue.
// The payload buffer read issued at acceptance returns in the next cycle, where the
// bit is picked or written back; a write to the byte read in that same cycle is forwarded.
// Reset clears the bit pointer, registers and per-byte valid flags; no clearing pass.
// A two-beat result queue absorbs out_stall; in_stall rises only when it would overflow.
module homoglyph_bit_embed_codec (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [11:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [7:0]                 in_address,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_result_byte,
  output logic                       out_carried,
  output logic [hbe_pkg::PTR_W-1:0]  out_bits_done
);
  import hbe_pkg::*;

  logic             mode_r;
  logic [PTR_W-1:0] pbits_r;
  logic             acc;
  logic             rd_en;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]       rd_data;
  s1_t              s1;
  logic             s1_vld;
  wr_t              wr;
  res_t             res;
  res_t             head;
  logic             pop;
  logic [1:0]       cnt;
  logic [7:0]       byte_cur;
  logic [7:0]       mask;
  logic [2:0]       fill;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EMBED;
      pbits_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == CFG_PAYLOAD_BITS) begin
        pbits_r <= cfg_data;
      end
    end
  end

  // Stall input when the queue would be full once the in-flight item is queued
  always_comb begin
    fill     = 3'(cnt) + 3'(s1_vld) - 3'(pop);
    in_stall = fill >= 3'd2;
    acc      = in_valid && !in_stall;
  end

  hbe_issue u_issue (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_cmd  (cmd_t'(in_command)),
    .in_addr (in_address),
    .in_data (in_data_byte),
    .pbits   (pbits_r),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1      (s1),
    .s1_vld  (s1_vld)
  );

  hbe_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Pick the current byte: forwarded write, stored data, or never-written zero
  always_comb begin
    if (s1.fwd_hit) begin
      byte_cur = s1.fwd_data;
    end else if (s1.byte_vld) begin
      byte_cur = rd_data;
    end else begin
      byte_cur = 8'h00;
    end
    mask = 8'h01 << s1.shift;
  end

  // Form the result and the write-back
  always_comb begin
    res.result_byte = 8'h00;
    res.carried     = s1.carried;
    res.bits_done   = s1.bits_done;
    wr.en           = 1'b0;
    wr.addr         = s1.addr;
    wr.data         = s1.data;
    case (s1.cmd)
      CMD_LOAD: begin
        wr.en = s1_vld && s1.addr_ok;
      end
      CMD_READ: begin
        res.result_byte = s1.addr_ok ? byte_cur : 8'h00;
      end
      CMD_CODE: begin
        res.result_byte = s1.data;
        if (s1.carried) begin
          if (mode_r == MODE_EMBED) begin
            res.result_byte = ((byte_cur & mask) != 8'h00) ?
                              CYRILLIC_FORM[s1.slot] : LATIN_FORM[s1.slot];
          end else begin
            wr.en   = s1_vld;
            wr.data = s1.kind ? (byte_cur | mask) : (byte_cur & ~mask);
          end
        end
      end
      CMD_RESTART: begin
        res.result_byte = 8'h00;
      end
      default: begin
        res.result_byte = 8'h00;
      end
    endcase
  end

  hbe_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_vld),
    .push_item (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .pop       (pop),
    .cnt       (cnt)
  );

  assign out_result_byte = head.result_byte;
  assign out_carried     = head.carried;
  assign out_bits_done   = head.bits_done;

endmodule

// ===== src/hbe_checker.sv =====
module hbe_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_result_byte,
  input logic                       out_carried,
  input logic [hbe_pkg::PTR_W-1:0]  out_bits_done
);
  import hbe_pkg::*;

  glyph_t out_glyph;

  assign out_glyph = classify(out_result_byte);

  // No result beat right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A carrying beat always advanced the pointer past zero
  a_carry_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carried |-> out_bits_done != '0)
    else $error("carried beat with zero bit count");

  // A carrying beat is always an alphabet letter
  a_carry_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carried |-> out_glyph.hit)
    else $error("carried beat is not an alphabet letter");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_byte) &&
    $stable(out_carried) && $stable(out_bits_done))
    else $error("stalled result beat changed");

endmodule

bind homoglyph_bit_embed_codec hbe_checker u_hbe_checker (.*);
